>>> rtl/core/hbmvc_pkg.sv
// Shared constants and types of the hashed bucket visited-state cache.
`default_nettype none

package hbmvc_pkg;

  // Fixed field widths of the channels
  localparam int KEY_W   = 64;
  localparam int FRAME_W = 16;
  localparam int HASH_W  = 32;

  // Parameter defaults
  localparam int BUCKETS_DEF  = 4096;
  localparam int WAYS_DEF     = 4;
  localparam int KEY_BITS_DEF = 64;

  // Item function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Finished hash handed from the hash unit to the bucket reduction
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] value;
  } hash_t;

endpackage

`default_nettype wire

>>> rtl/core/hbmvc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface hbmvc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [hbmvc_pkg::KEY_W-1:0]   state_key;
  logic [hbmvc_pkg::FRAME_W-1:0] frame;

  modport source (output valid, func, state_key, frame, input ready);
  modport sink   (input valid, func, state_key, frame, output ready);
endinterface

interface hbmvc_out_if;
  logic valid;
  logic ready;
  logic enqueue;
  logic hit;

  modport source (output valid, enqueue, hit, input ready);
  modport sink   (input valid, enqueue, hit, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hashed_bucket_mtf_visited_cache.sv
// Top level of the hashed bucket move-to-front visited-state cache.
//
// Usage: items arrive on in_i (valid/ready). An item with func = insert hashes
// the low KEY_BITS bits of state_key, picks one bucket of WAYS entries and
// updates it: a matching entry moves to the front and takes the new frame, a
// miss pushes the bucket down and drops the last entry. Every item yields one
// transfer on out_o carrying enqueue and hit. A clear item zeroes the store and
// returns enqueue = 0, hit = 0.
// An insert runs through the iterative hash over the key bytes (whole 4-byte
// groups, then any trailing bytes, then the final avalanche), the three-stage
// reduction modulo BUCKETS and the bucket memory read-modify-write.
// One item is in flight at a time: in_i.ready rises in the cycle the result
// first shows on out_o, also while that result still waits there.
// Reset sweeps the bucket memory one row per cycle with in_i.ready low. A clear
// item runs the same sweep, then registers its result, and in_i.ready rises
// with that result.
// If out_o stalls, a finished bucket update holds in its read stage until the
// output register frees up; the memory is written only then.

`default_nettype none

module hashed_bucket_mtf_visited_cache #(
  parameter int BUCKETS  = hbmvc_pkg::BUCKETS_DEF,
  parameter int WAYS     = hbmvc_pkg::WAYS_DEF,
  parameter int KEY_BITS = hbmvc_pkg::KEY_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  hbmvc_in_if.sink          in_i,
  hbmvc_out_if.source       out_o
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW    = KEY_BITS + hbmvc_pkg::FRAME_W;
  localparam int ROW_W = WAYS * EW;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CDONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [BW-1:0] cnt_q, cnt_d;
  logic clr_res_q, clr_res_d;
  logic [BW-1:0] idx_q;
  logic [KEY_BITS-1:0] key_q;
  logic [hbmvc_pkg::FRAME_W-1:0] frame_q;

  logic out_valid_q, out_valid_d;
  logic enqueue_q, enqueue_d, hit_q, hit_d;

  logic in_xfer, out_free;
  hbmvc_pkg::hash_t hash;
  logic idx_valid;
  logic [BW-1:0] idx;

  logic ram_we, ram_re;
  logic [BW-1:0] ram_addr;
  logic [ROW_W-1:0] ram_wdata, rd_data, row_new;

  logic [WAYS-1:0] match;
  logic [WW-1:0] hit_way, shift;
  logic [hbmvc_pkg::FRAME_W-1:0] hit_frame;
  logic row_hit, row_enq;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Hash the masked key, then reduce to a bucket index
  hbmvc_sfh #(
    .KEY_BITS (KEY_BITS)
  ) u_sfh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer && (in_i.func == hbmvc_pkg::FUNC_INSERT)),
    .key_i   (64'(in_i.state_key[KEY_BITS-1:0])),
    .hash_o  (hash)
  );

  hbmvc_reduce #(
    .BUCKETS (BUCKETS)
  ) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hash_i      (hash),
    .idx_valid_o (idx_valid),
    .idx_o       (idx)
  );

  // One row per bucket; way w sits at [w*EW +: EW] as {key, frame}
  hbmvc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_data)
  );

  assign ram_re    = (state_q == S_HASH) && idx_valid;
  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_READ) && out_free);
  assign ram_addr  = (state_q == S_CLEAR) ? cnt_q : ((state_q == S_READ) ? idx_q : idx);
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : row_new;

  // Compare all ways at once; the lowest matching way wins
  always_comb begin
    match     = '0;
    hit_way   = '0;
    hit_frame = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (rd_data[w*EW + hbmvc_pkg::FRAME_W +: KEY_BITS] == key_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way   = WW'(w);
        hit_frame = rd_data[w*EW +: hbmvc_pkg::FRAME_W];
      end
    end
  end

  assign row_hit = |match;
  assign row_enq = row_hit ? (hit_frame > frame_q) : 1'b1;
  // On a miss the whole bucket shifts, as if the last way had matched
  assign shift   = row_hit ? hit_way : WW'(WAYS - 1);

  always_comb begin
    row_new       = rd_data;
    row_new[0 +: EW] = {key_q, frame_q};
    for (int i = 1; i < WAYS; i++) begin
      if (WW'(i) <= shift) begin
        row_new[i*EW +: EW] = rd_data[(i-1)*EW +: EW];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_res_d   = clr_res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    enqueue_d   = enqueue_q;
    hit_d       = hit_q;
    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BW'(BUCKETS - 1)) begin
          cnt_d   = '0;
          state_d = clr_res_q ? S_CDONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.func == hbmvc_pkg::FUNC_CLEAR) begin
            clr_res_d = 1'b1;
            cnt_d     = '0;
            state_d   = S_CLEAR;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (idx_valid) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        // Hold the read row until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          enqueue_d   = row_enq;
          hit_d       = row_hit;
          state_d     = S_IDLE;
        end
      end
      S_CDONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          enqueue_d   = 1'b0;
          hit_d       = 1'b0;
          clr_res_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_res_q   <= clr_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enqueue_q <= enqueue_d;
    hit_q     <= hit_d;
    if (in_xfer) begin
      key_q   <= in_i.state_key[KEY_BITS-1:0];
      frame_q <= in_i.frame;
    end
    if (ram_re) begin
      idx_q <= idx;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.enqueue = enqueue_q;
  assign out_o.hit     = hit_q;

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("bucket memory read and write in the same cycle");

  a_idx_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_valid |-> (state_q == S_HASH))
    else $error("bucket index arrived outside the hash wait");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_READ || $past(state_q) == S_CDONE))
    else $error("result registered without a bucket update or clear");

  a_insert_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.func == hbmvc_pkg::FUNC_INSERT) |=> (state_q == S_HASH))
    else $error("insert transfer did not start the hash");

  a_clear_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("input accepted during the clearing sweep");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hbmvc_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module hbmvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hbmvc_sfh.sv
// Iterative SuperFastHash over the low key bytes, one round per cycle.
`default_nettype none

module hbmvc_sfh #(
  parameter int KEY_BITS = hbmvc_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hbmvc_pkg::KEY_W-1:0] key_i,
  output hbmvc_pkg::hash_t                 hash_o
);

  localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int QUADS     = KEY_BYTES / 4;
  localparam int REMB      = KEY_BYTES % 4;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_QUAD = 5'b00010,
    H_REM  = 5'b00100,
    H_FIN1 = 5'b01000,
    H_FIN2 = 5'b10000
  } h_state_e;

  localparam h_state_e H_FIRST = (QUADS > 0) ? H_QUAD : ((REMB > 0) ? H_REM : H_FIN1);

  h_state_e st_q, st_d;
  logic [1:0] cnt_q, cnt_d;
  logic done_q, done_d;
  logic [hbmvc_pkg::HASH_W-1:0] h_q, h_d;
  logic [hbmvc_pkg::KEY_W-1:0] key_q, key_d;

  logic [31:0] quad_a, quad_t, quad_b, quad_h;
  logic [31:0] r3_a, r3_b, r3_c, r3_h, r2_b, r2_h, r1_a, r1_b, r1_h, rem_h;
  logic [31:0] f1_a, f1_b, f1_h, f2_a, f2_b, f2_h;

  // One full block of four bytes
  assign quad_a = h_q + 32'(key_q[15:0]);
  assign quad_t = (32'(key_q[31:16]) << 11) ^ quad_a;
  assign quad_b = (quad_a << 16) ^ quad_t;
  assign quad_h = quad_b + (quad_b >> 11);

  // Trailing bytes; single bytes are sign extended
  assign r3_a = h_q + 32'(key_q[15:0]);
  assign r3_b = r3_a ^ (r3_a << 16);
  assign r3_c = r3_b ^ ({{24{key_q[23]}}, key_q[23:16]} << 18);
  assign r3_h = r3_c + (r3_c >> 11);
  assign r2_b = r3_a ^ (r3_a << 11);
  assign r2_h = r2_b + (r2_b >> 17);
  assign r1_a = h_q + {{24{key_q[7]}}, key_q[7:0]};
  assign r1_b = r1_a ^ (r1_a << 10);
  assign r1_h = r1_b + (r1_b >> 1);
  assign rem_h = (REMB == 3) ? r3_h : ((REMB == 2) ? r2_h : r1_h);

  // Final avalanche, split over the states H_FIN1 and H_FIN2
  assign f1_a = h_q ^ (h_q << 3);
  assign f1_b = f1_a + (f1_a >> 5);
  assign f1_h = f1_b ^ (f1_b << 4);
  assign f2_a = h_q + (h_q >> 17);
  assign f2_b = f2_a ^ (f2_a << 25);
  assign f2_h = f2_b + (f2_b >> 6);

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    h_d    = h_q;
    key_d  = key_q;
    done_d = 1'b0;
    case (st_q)
      H_IDLE: begin
        if (start_i) begin
          h_d   = 32'(KEY_BYTES);
          key_d = key_i;
          cnt_d = '0;
          st_d  = H_FIRST;
        end
      end
      H_QUAD: begin
        h_d   = quad_h;
        key_d = key_q >> 32;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'(QUADS - 1)) begin
          st_d = (REMB > 0) ? H_REM : H_FIN1;
        end
      end
      H_REM: begin
        h_d  = rem_h;
        st_d = H_FIN1;
      end
      H_FIN1: begin
        h_d  = f1_h;
        st_d = H_FIN2;
      end
      H_FIN2: begin
        h_d    = f2_h;
        done_d = 1'b1;
        st_d   = H_IDLE;
      end
      default: st_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= H_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    key_q <= key_d;
  end

  assign hash_o = '{valid: done_q, value: h_q};

endmodule

`default_nettype wire

>>> rtl/core/hbmvc_reduce.sv
// Three-stage hash modulo BUCKETS by reciprocal multiply and one correction.
`default_nettype none

module hbmvc_reduce #(
  parameter int BUCKETS = hbmvc_pkg::BUCKETS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  hbmvc_pkg::hash_t          hash_i,
  output logic                      idx_valid_o,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] idx_o
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // floor(2^32 / BUCKETS): quotient estimate is short by at most one
  localparam logic [31:0] MAGIC = (BUCKETS == 1) ? 32'hFFFF_FFFF
                                                 : 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [31:0] BUCKET_C = 32'(BUCKETS);

  logic        v1_q, v2_q, v3_q;
  logic [31:0] h1_q, h2_q, q1_q, qb2_q, r3_q;
  logic [63:0] prod;
  logic [31:0] r32, r_fix;

  assign prod  = {32'd0, hash_i.value} * {32'd0, MAGIC};
  assign r32   = h2_q - qb2_q;
  assign r_fix = (r32 >= BUCKET_C) ? (r32 - BUCKET_C) : r32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= hash_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q  <= hash_i.value;
    q1_q  <= prod[63:32];
    h2_q  <= h1_q;
    qb2_q <= q1_q * BUCKET_C;
    r3_q  <= r_fix;
  end

  assign idx_valid_o = v3_q;
  assign idx_o       = r3_q[BW-1:0];

endmodule

`default_nettype wire
